// ===== design/min_priority_queue_array_core_assert.svh =====
// ----------------------------------------------------------------------------
// min_priority_queue_array_core assertion macros
// concurrent assertion wrappers shared by the queue rtl
// ----------------------------------------------------------------------------
`ifndef MIN_PRIORITY_QUEUE_ARRAY_CORE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_ARRAY_CORE_ASSERT_SVH

// property checked on every rising edge outside reset
`define MPQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the condition
`define MPQ_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/mpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mpq_pkg
// shared types and constants of the minimum priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package mpq_pkg;

  localparam int KEY_W     = 32;
  localparam int FILL_W    = 4;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 8;
  localparam int OUT_W     = ((KEY_W + STATUS_W + FILL_W + 7) / 8) * 8;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_INSERT  = 2'd1,
    OP_EXTRACT = 2'd2
  } cell_op_t;

  // broadcast to every cell
  typedef struct packed {
    cell_op_t op;
    key_t     key;
  } cell_cmd_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic valid;
    logic gt;
    key_t key;
  } cell_link_t;

endpackage

`default_nettype wire

// ===== design/mpq_cell.sv =====
// ----------------------------------------------------------------------------
// mpq_cell
// one slot of the sorted queue; takes new key, left or right neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module mpq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mpq_pkg::cell_cmd_t cmd,
  input  wire mpq_pkg::cell_link_t left,
  input  wire mpq_pkg::cell_link_t right,
  output mpq_pkg::cell_link_t     link
);

  logic          valid_r;
  logic          valid_nxt;
  mpq_pkg::key_t key_r;
  mpq_pkg::key_t key_nxt;
  logic          gt;

  // new key sorts before this slot (empty slot counts as infinite)
  assign gt = !valid_r || (cmd.key < key_r);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    unique case (cmd.op)
      mpq_pkg::OP_INSERT: begin
        if (gt) begin
          if (left.gt) begin
            valid_nxt = left.valid;
            key_nxt   = left.key;
          end else begin
            valid_nxt = 1'b1;
            key_nxt   = cmd.key;
          end
        end
      end
      mpq_pkg::OP_EXTRACT: begin
        valid_nxt = right.valid;
        key_nxt   = right.key;
      end
      default: begin
        valid_nxt = valid_r;
        key_nxt   = key_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.key   = key_r;

endmodule

`default_nettype wire

// ===== design/min_priority_queue_array_core.sv =====
// the result word is registered when the request word is taken and shows in the next cycle
// throughput: one request per cycle while the result side keeps up
// the cell chain keeps keys sorted, so the minimum always sits in cell 0
// and every insert or extract updates all cells in the same cycle
// reset: synchronous active-low rst_n empties the queue and the output stage
// ----------------------------------------------------------------------------
// min_priority_queue_array_core
// bounded minimum priority queue built from a chain of sorting cells
// ----------------------------------------------------------------------------
`default_nettype none

`include "min_priority_queue_array_core_assert.svh"

module min_priority_queue_array_core #(
  parameter int DEPTH = mpq_pkg::DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [mpq_pkg::KEY_W-1:0]  in_tdata,   // value[31:0]
  input  wire logic [0:0]                 in_tuser,   // req_type[0]
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [mpq_pkg::OUT_W-1:0]       out_tdata   // result_value[31:0],
                                                      // status[33:32],
                                                      // fill_count[37:34], zero pad
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int PAD_W = mpq_pkg::OUT_W - mpq_pkg::KEY_W - mpq_pkg::STATUS_W
                         - mpq_pkg::FILL_W;

  localparam mpq_pkg::cell_link_t LINK_HEAD = '{valid: 1'b1, gt: 1'b0, key: '0};
  localparam mpq_pkg::cell_link_t LINK_TAIL = '{valid: 1'b0, gt: 1'b1, key: '0};

  mpq_pkg::cell_link_t links [DEPTH];
  mpq_pkg::cell_cmd_t  cmd;

  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                full;
  logic                empty;
  logic                accept;
  logic                is_insert;
  mpq_pkg::key_t       res_nxt;
  mpq_pkg::status_t    status_nxt;
  logic [CNT_W+3:0]    cnt_ext;

  logic                out_valid_r;
  mpq_pkg::key_t       res_r;
  mpq_pkg::status_t    status_r;
  logic [mpq_pkg::FILL_W-1:0] fill_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign empty      = (cnt_r == '0);
  assign is_insert  = (mpq_pkg::req_t'(in_tuser[0]) == mpq_pkg::REQ_INSERT);

  always_comb begin
    cmd.key    = $signed(in_tdata);
    cmd.op     = mpq_pkg::OP_HOLD;
    cnt_nxt    = cnt_r;
    res_nxt    = '0;
    status_nxt = mpq_pkg::ST_OK;
    if (is_insert) begin
      if (full) begin
        status_nxt = mpq_pkg::ST_OVERFLOW;
      end else begin
        cmd.op  = accept ? mpq_pkg::OP_INSERT : mpq_pkg::OP_HOLD;
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      if (empty) begin
        status_nxt = mpq_pkg::ST_UNDERFLOW;
      end else begin
        cmd.op  = accept ? mpq_pkg::OP_EXTRACT : mpq_pkg::OP_HOLD;
        cnt_nxt = cnt_r - 1'b1;
        res_nxt = links[0].key;
      end
    end
  end

  assign cnt_ext = {4'b0000, cnt_nxt};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mpq_pkg::cell_link_t left;
    mpq_pkg::cell_link_t right;
    if (i == 0) begin : g_head
      assign left = LINK_HEAD;
    end else begin : g_body
      assign left = links[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = LINK_TAIL;
    end else begin : g_next
      assign right = links[i+1];
    end
    mpq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (left),
      .right (right),
      .link  (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r    <= res_nxt;
      status_r <= status_nxt;
      fill_r   <= cnt_ext[3:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, fill_r, status_r, res_r};

  // checks on the cell chain
  logic [DEPTH-1:0] valid_vec;
  logic [DEPTH:0]   valid_inc;
  logic             prefix_ok;
  logic             sorted_ok;

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = links[i].valid;
    end
    for (int i = 1; i < DEPTH; i++) begin
      if (links[i].valid && (links[i].key < links[i-1].key)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  assign valid_inc = {1'b0, valid_vec} + 1'b1;
  assign prefix_ok = ((valid_inc[DEPTH-1:0] & valid_vec) == '0);

  `MPQ_ASSERT(a_cnt_matches_cells, clk, rst_n,
              $countones(valid_vec) == int'(cnt_r), "count disagrees with cell valid bits")
  `MPQ_ASSERT(a_cells_packed, clk, rst_n, prefix_ok, "gap in occupied cells")
  `MPQ_ASSERT(a_cells_sorted, clk, rst_n, sorted_ok, "cell chain out of order")
  `MPQ_ASSERT_NEXT(a_overflow_holds, clk, rst_n, accept && is_insert && full,
                   $stable(cnt_r) && (status_r == mpq_pkg::ST_OVERFLOW),
                   "overflow changed queue state")

endmodule

`default_nettype wire
